FILE: rtl/core/rpws_pkg.sv
`default_nettype none

package rpws_pkg;

	// Panel dimension register width and panel coordinate width on the link.
	localparam int DIM_BITS   = 11;
	localparam int PANEL_BITS = 16;
	localparam int COLOR_BITS = 16;
	localparam int BYTE_BITS  = 8;

	// Configuration register indexes.
	localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
	localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ROTATION     = 2'd2;

	// Rotation codes.
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// Panel command bytes.
	localparam logic [BYTE_BITS-1:0] CMD_COLUMN_SET = 8'h2A;
	localparam logic [BYTE_BITS-1:0] CMD_ROW_SET    = 8'h2B;
	localparam logic [BYTE_BITS-1:0] CMD_MEM_WRITE  = 8'h2C;

	// Result of clipping and rotating one pixel.
	typedef struct packed {
		logic                  keep;
		logic [PANEL_BITS-1:0] px;
		logic [PANEL_BITS-1:0] py;
	} map_t;

	// Pixel handed to the byte sequencer.
	typedef struct packed {
		logic [PANEL_BITS-1:0] px;
		logic [PANEL_BITS-1:0] py;
		logic [COLOR_BITS-1:0] color;
	} pix_t;

endpackage

`default_nettype wire

FILE: rtl/core/rpws_map.sv
`default_nettype none

module rpws_map #(
	parameter int COORD_BITS = 10
) (
	input  wire logic [COORD_BITS-1:0]         pos_x,
	input  wire logic [COORD_BITS-1:0]         pos_y,
	input  wire logic [rpws_pkg::DIM_BITS-1:0] panel_width,
	input  wire logic [rpws_pkg::DIM_BITS-1:0] panel_height,
	input  wire logic [1:0]                    rotation,
	output rpws_pkg::map_t                     map
);

	localparam int PB = rpws_pkg::PANEL_BITS;

	logic [PB-1:0] lx;
	logic [PB-1:0] ly;
	logic [PB-1:0] w16;
	logic [PB-1:0] h16;
	logic [PB-1:0] lw;
	logic [PB-1:0] lh;
	logic [PB-1:0] flip_x;
	logic [PB-1:0] flip_y;
	logic          swap;

	// Widen everything to the panel coordinate width; wrap is modulo 2^16.
	assign lx     = PB'(pos_x);
	assign ly     = PB'(pos_y);
	assign w16    = PB'(panel_width);
	assign h16    = PB'(panel_height);
	assign flip_x = w16 - PB'(1) - lx;
	assign flip_y = h16 - PB'(1) - ly;

	// Logical extent swaps at 90 and 270 degrees.
	assign swap = (rotation == rpws_pkg::ROT_90) || (rotation == rpws_pkg::ROT_270);
	assign lw   = swap ? h16 : w16;
	assign lh   = swap ? w16 : h16;

	// Clip and map to panel space.
	always_comb begin
		map.keep = (lx < lw) && (ly < lh);
		unique case (rotation)
			rpws_pkg::ROT_90: begin
				map.px = flip_y;
				map.py = lx;
			end
			rpws_pkg::ROT_180: begin
				map.px = flip_x;
				map.py = flip_y;
			end
			rpws_pkg::ROT_270: begin
				map.px = ly;
				map.py = flip_x;
			end
			rpws_pkg::ROT_0: begin
				map.px = lx;
				map.py = ly;
			end
			default: begin
				map.px = lx;
				map.py = ly;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/rpws_seq.sv
`default_nettype none

module rpws_seq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           load,
	input  wire rpws_pkg::pix_t                 pix,
	output logic                                free,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [rpws_pkg::BYTE_BITS-1:0]      out_byte,
	output logic                                is_command,
	output logic                                release_select,
	output logic                                last
);

	localparam logic [3:0] STEP_COL_CMD = 4'd0;
	localparam logic [3:0] STEP_X0_HI   = 4'd1;
	localparam logic [3:0] STEP_X0_LO   = 4'd2;
	localparam logic [3:0] STEP_X1_HI   = 4'd3;
	localparam logic [3:0] STEP_X1_LO   = 4'd4;
	localparam logic [3:0] STEP_ROW_CMD = 4'd5;
	localparam logic [3:0] STEP_Y0_HI   = 4'd6;
	localparam logic [3:0] STEP_Y0_LO   = 4'd7;
	localparam logic [3:0] STEP_Y1_HI   = 4'd8;
	localparam logic [3:0] STEP_Y1_LO   = 4'd9;
	localparam logic [3:0] STEP_MEM_CMD = 4'd10;
	localparam logic [3:0] STEP_C_HI    = 4'd11;
	localparam logic [3:0] STEP_C_LO    = 4'd12;

	rpws_pkg::pix_t pix_q;
	logic           busy_q;
	logic [3:0]     step_q;
	logic           emit;
	logic           done;
	logic [7:0]     nxt_byte;
	logic           nxt_cmd;
	logic           nxt_rel;

	// A byte moves into the output register when it is empty or being taken.
	assign emit = busy_q && (!out_valid || !out_stall);
	assign done = emit && (step_q == STEP_C_LO);
	assign free = !busy_q || done;

	// Byte selection for the current step.
	always_comb begin
		nxt_cmd = 1'b0;
		nxt_rel = 1'b0;
		unique case (step_q) inside
			STEP_COL_CMD: begin
				nxt_byte = rpws_pkg::CMD_COLUMN_SET;
				nxt_cmd  = 1'b1;
				nxt_rel  = 1'b1;
			end
			STEP_X0_HI, STEP_X1_HI: nxt_byte = pix_q.px[15:8];
			STEP_X0_LO, STEP_X1_LO: begin
				nxt_byte = pix_q.px[7:0];
				nxt_rel  = 1'b1;
			end
			STEP_ROW_CMD: begin
				nxt_byte = rpws_pkg::CMD_ROW_SET;
				nxt_cmd  = 1'b1;
				nxt_rel  = 1'b1;
			end
			STEP_Y0_HI, STEP_Y1_HI: nxt_byte = pix_q.py[15:8];
			STEP_Y0_LO, STEP_Y1_LO: begin
				nxt_byte = pix_q.py[7:0];
				nxt_rel  = 1'b1;
			end
			STEP_MEM_CMD: begin
				nxt_byte = rpws_pkg::CMD_MEM_WRITE;
				nxt_cmd  = 1'b1;
				nxt_rel  = 1'b1;
			end
			STEP_C_HI: nxt_byte = pix_q.color[15:8];
			STEP_C_LO: begin
				nxt_byte = pix_q.color[7:0];
				nxt_rel  = 1'b1;
			end
			default: nxt_byte = '0;
		endcase
	end

	// Step counter; a new pixel may load in the cycle the previous one ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_COL_CMD;
		end else if (load) begin
			busy_q <= 1'b1;
			step_q <= STEP_COL_CMD;
		end else if (emit) begin
			busy_q <= !done;
			step_q <= step_q + 4'd1;
		end
	end

	// Pixel payload.
	always_ff @(posedge clk) begin
		if (load) begin
			pix_q <= pix;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte       <= nxt_byte;
			is_command     <= nxt_cmd;
			release_select <= nxt_rel;
			last           <= (step_q == STEP_C_LO);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rotated_pixel_write_sequencer.sv
// A kept pixel waits in the input register until the sequencer is free, is loaded
// into the sequencer, and leaves as bytes through the output register, one byte per
// cycle while out_stall is low; a clipped pixel drains at once and gives no bytes.
// A new item is taken while the previous pixel's bytes are still going out.
// Reset (arst_n low, asynchronous) empties all stages and restores the
// panel size to 128 by 160 at rotation zero.
`default_nettype none

module rotated_pixel_write_sequencer #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [rpws_pkg::DIM_BITS-1:0]  cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [COORD_BITS-1:0]          pos_x,
	input  wire logic [COORD_BITS-1:0]          pos_y,
	input  wire logic [rpws_pkg::COLOR_BITS-1:0] pixel_color,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [rpws_pkg::BYTE_BITS-1:0]      out_byte,
	output logic                                is_command,
	output logic                                release_select,
	output logic                                last
);

	logic [rpws_pkg::DIM_BITS-1:0]   width_q;
	logic [rpws_pkg::DIM_BITS-1:0]   height_q;
	logic [1:0]                      rot_q;
	logic                            valid_s1;
	logic [COORD_BITS-1:0]           x_s1;
	logic [COORD_BITS-1:0]           y_s1;
	logic [rpws_pkg::COLOR_BITS-1:0] color_s1;
	rpws_pkg::map_t                  map;
	rpws_pkg::pix_t                  pix;
	logic                            seq_free;
	logic                            adv_s1;
	logic                            load;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rpws_pkg::DIM_BITS'(128);
			height_q <= rpws_pkg::DIM_BITS'(160);
			rot_q    <= rpws_pkg::ROT_0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rpws_pkg::REG_PANEL_WIDTH:  width_q  <= cfg_data;
				rpws_pkg::REG_PANEL_HEIGHT: height_q <= cfg_data;
				rpws_pkg::REG_ROTATION:     rot_q    <= cfg_data[1:0];
				default:                    ;
			endcase
		end
	end

	// The input stage drains at once for a clipped pixel, else when the sequencer frees.
	assign adv_s1   = valid_s1 && (!map.keep || seq_free);
	assign load     = valid_s1 && map.keep && seq_free;
	assign in_stall = valid_s1 && !adv_s1;

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			x_s1     <= pos_x;
			y_s1     <= pos_y;
			color_s1 <= pixel_color;
		end
	end

	rpws_map #(
		.COORD_BITS(COORD_BITS)
	) u_map (
		.pos_x       (x_s1),
		.pos_y       (y_s1),
		.panel_width (width_q),
		.panel_height(height_q),
		.rotation    (rot_q),
		.map         (map)
	);

	assign pix.px    = map.px;
	assign pix.py    = map.py;
	assign pix.color = color_s1;

	rpws_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.pix           (pix),
		.free          (seq_free),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.is_command    (is_command),
		.release_select(release_select),
		.last          (last)
	);

endmodule

`default_nettype wire

FILE: rtl/core/rpws_checker.sv
`default_nettype none

module rpws_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       is_command,
	input wire logic       release_select,
	input wire logic       last
);

	// A stalled item stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	// The closing byte is the color low byte, which releases select.
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !is_command && release_select)
		else $error("last byte is not a releasing data byte");

	// Every command byte releases select and is one of the three commands.
	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_command |-> release_select &&
			(out_byte == rpws_pkg::CMD_COLUMN_SET || out_byte == rpws_pkg::CMD_ROW_SET ||
			out_byte == rpws_pkg::CMD_MEM_WRITE))
		else $error("bad command byte");

	// The byte after a final byte opens a new sequence with the column command.
	a_seq_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last ##1 out_valid |->
			is_command && out_byte == rpws_pkg::CMD_COLUMN_SET)
		else $error("sequence does not start with column set");

endmodule

bind rotated_pixel_write_sequencer rpws_checker u_rpws_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.out_byte      (out_byte),
	.is_command    (is_command),
	.release_select(release_select),
	.last          (last)
);

`default_nettype wire
